// ===== hw/rtl/dlle_pkg.sv =====
// Package for the doubly linked list engine.
// Holds payload structs, codes and the controller/datapath interface types.
// No dependencies.
package dlle_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] item_value;
    logic               last;
    logic [6:0]         node_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_SCAN,
    ST_APP_WR,
    ST_APP_LINK,
    ST_INS_WR,
    ST_INS_LINK,
    ST_DEL,
    ST_READ
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_WALK_START,
    CMD_WALK_STEP,
    CMD_HIT,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_APP_WR,
    CMD_APP_LINK,
    CMD_INS_WR,
    CMD_INS_LINK,
    CMD_DEL
  } cmd_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    emit;
    status_t status;
    logic    item;
    logic    last;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic head_nil;
    logic pool_full;
    logic key_hit;
    logic walk_end;
    logic free_hit;
    logic clr_done;
  } sts_t;

endpackage

// ===== hw/rtl/dlle_ctrl.sv =====
// Controller FSM for the doubly linked list engine.
// Sequences walk, slot scan and link updates; uses dlle_pkg.
module dlle_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dlle_pkg::sts_t sts,
  output dlle_pkg::ctl_t ctl,
  output logic          busy
);

  dlle_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlle_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != dlle_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    ctl.cmd    = dlle_pkg::CMD_NONE;
    ctl.emit   = 1'b0;
    ctl.status = dlle_pkg::STAT_OK;
    ctl.item   = 1'b0;
    ctl.last   = 1'b1;
    case (state)
      dlle_pkg::ST_CLEAR: begin
        ctl.cmd = dlle_pkg::CMD_CLEAR;
        if (sts.clr_done) state_next = dlle_pkg::ST_IDLE;
      end
      dlle_pkg::ST_IDLE: begin
        if (start) begin
          ctl.cmd    = dlle_pkg::CMD_LOAD;
          state_next = dlle_pkg::ST_DECODE;
        end
      end
      dlle_pkg::ST_DECODE: begin
        if (sts.op == dlle_pkg::OP_APPEND) begin
          if (sts.pool_full) begin
            ctl.emit   = 1'b1;
            ctl.status = dlle_pkg::STAT_FULL;
            state_next = dlle_pkg::ST_IDLE;
          end else begin
            ctl.cmd    = dlle_pkg::CMD_SCAN_START;
            state_next = dlle_pkg::ST_SCAN;
          end
        end else if (sts.head_nil) begin
          ctl.emit   = 1'b1;
          ctl.status = dlle_pkg::STAT_EMPTY;
          state_next = dlle_pkg::ST_IDLE;
        end else begin
          ctl.cmd    = dlle_pkg::CMD_WALK_START;
          state_next = (sts.op == dlle_pkg::OP_READ) ? dlle_pkg::ST_READ : dlle_pkg::ST_WALK;
        end
      end
      dlle_pkg::ST_WALK: begin
        if (sts.key_hit) begin
          ctl.cmd = dlle_pkg::CMD_HIT;
          if (sts.op == dlle_pkg::OP_INSERT) begin
            if (sts.pool_full) begin
              ctl.emit   = 1'b1;
              ctl.status = dlle_pkg::STAT_FULL;
              state_next = dlle_pkg::ST_IDLE;
            end else begin
              state_next = dlle_pkg::ST_SCAN;
            end
          end else begin
            state_next = dlle_pkg::ST_DEL;
          end
        end else if (sts.walk_end) begin
          ctl.emit   = 1'b1;
          ctl.status = dlle_pkg::STAT_NOT_FOUND;
          state_next = dlle_pkg::ST_IDLE;
        end else begin
          ctl.cmd = dlle_pkg::CMD_WALK_STEP;
        end
      end
      dlle_pkg::ST_SCAN: begin
        if (sts.free_hit) begin
          state_next = (sts.op == dlle_pkg::OP_APPEND) ? dlle_pkg::ST_APP_WR
                                                       : dlle_pkg::ST_INS_WR;
        end else begin
          ctl.cmd = dlle_pkg::CMD_SCAN_STEP;
        end
      end
      dlle_pkg::ST_APP_WR: begin
        ctl.cmd    = dlle_pkg::CMD_APP_WR;
        state_next = dlle_pkg::ST_APP_LINK;
      end
      dlle_pkg::ST_APP_LINK: begin
        ctl.cmd    = dlle_pkg::CMD_APP_LINK;
        ctl.emit   = 1'b1;
        state_next = dlle_pkg::ST_IDLE;
      end
      dlle_pkg::ST_INS_WR: begin
        ctl.cmd    = dlle_pkg::CMD_INS_WR;
        state_next = dlle_pkg::ST_INS_LINK;
      end
      dlle_pkg::ST_INS_LINK: begin
        ctl.cmd    = dlle_pkg::CMD_INS_LINK;
        ctl.emit   = 1'b1;
        state_next = dlle_pkg::ST_IDLE;
      end
      dlle_pkg::ST_DEL: begin
        ctl.cmd    = dlle_pkg::CMD_DEL;
        ctl.emit   = 1'b1;
        state_next = dlle_pkg::ST_IDLE;
      end
      dlle_pkg::ST_READ: begin
        ctl.emit = 1'b1;
        ctl.item = 1'b1;
        ctl.last = sts.walk_end;
        if (sts.walk_end) begin
          state_next = dlle_pkg::ST_IDLE;
        end else begin
          ctl.cmd = dlle_pkg::CMD_WALK_STEP;
        end
      end
      default: begin
        state_next = dlle_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dlle_dp.sv =====
// Datapath for the doubly linked list engine: node/link/free memories,
// head/tail/size registers, walk and scan counters, result register. Uses dlle_pkg.
module dlle_dp #(
  parameter int NODES      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  dlle_pkg::req_t req,
  input  dlle_pkg::ctl_t ctl,
  output dlle_pkg::sts_t sts,
  output dlle_pkg::rsp_t rsp,
  output logic           rsp_valid
);

  localparam int IW = $clog2(NODES);
  localparam int PW = $clog2(NODES + 1);
  localparam logic [PW-1:0] NIL  = PW'(NODES);
  localparam logic [PW-1:0] LAST = PW'(NODES - 1);
  localparam logic [IW-1:0] TOP  = IW'(NODES - 1);

  logic [VALUE_BITS-1:0] val_mem  [NODES];
  logic [PW-1:0]         next_mem [NODES];
  logic [PW-1:0]         prev_mem [NODES];
  logic                  free_mem [NODES];

  logic [VALUE_BITS-1:0] rd_val;
  logic [PW-1:0]         rd_next, rd_prev;
  logic                  rd_free;
  logic [IW-1:0]         rd_addr;

  dlle_pkg::op_t         op;
  logic [VALUE_BITS-1:0] val, key;
  logic [PW-1:0]         head, tail, size, size_next;
  logic [PW-1:0]         cur, steps, tgt, prv, nxt;
  logic [IW-1:0]         scan;

  logic [VALUE_BITS+31:0] val_ext, key_ext;
  logic [VALUE_BITS+31:0] item_ext;
  logic [PW+6:0]          cnt_ext;
  logic [PW-1:0]          slot;

  // write port controls
  logic                  val_we, next_we, prev_we, free_we;
  logic [IW-1:0]         val_wa, next_wa, prev_wa, free_wa;
  logic [PW-1:0]         next_wd, prev_wd;
  logic                  free_wd;

  assign val_ext  = {{VALUE_BITS{req.value[31]}}, req.value};
  assign key_ext  = {{VALUE_BITS{req.key[31]}}, req.key};
  assign item_ext = {32'd0, rd_val};
  assign cnt_ext  = {7'd0, size_next};
  assign slot     = PW'(scan);

  assign sts.op        = op;
  assign sts.head_nil  = (head >= NIL);
  assign sts.pool_full = (size == NIL);
  assign sts.key_hit   = (rd_val == key);
  assign sts.walk_end  = (rd_next >= NIL) || (steps == LAST);
  assign sts.free_hit  = rd_free;
  assign sts.clr_done  = (scan == TOP);

  always_comb begin
    case (ctl.cmd)
      dlle_pkg::CMD_WALK_START: rd_addr = head[IW-1:0];
      dlle_pkg::CMD_WALK_STEP:  rd_addr = rd_next[IW-1:0];
      dlle_pkg::CMD_SCAN_STEP:  rd_addr = scan + 1'b1;
      default:                  rd_addr = '0;
    endcase
  end

  always_comb begin
    size_next = size;
    case (ctl.cmd)
      dlle_pkg::CMD_APP_LINK,
      dlle_pkg::CMD_INS_LINK: size_next = size + 1'b1;
      dlle_pkg::CMD_DEL:      if (size != '0) size_next = size - 1'b1;
      default:                size_next = size;
    endcase
  end

  always_comb begin
    val_we  = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    free_we = 1'b0;
    val_wa  = scan;
    next_wa = scan;
    prev_wa = scan;
    free_wa = scan;
    next_wd = NIL;
    prev_wd = tail;
    free_wd = 1'b0;
    case (ctl.cmd)
      dlle_pkg::CMD_CLEAR: begin
        free_we = 1'b1;
        free_wd = 1'b1;
      end
      dlle_pkg::CMD_APP_WR: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        free_we = 1'b1;
      end
      dlle_pkg::CMD_APP_LINK: begin
        next_we = (tail < NIL);
        next_wa = tail[IW-1:0];
        next_wd = slot;
      end
      dlle_pkg::CMD_INS_WR: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        free_we = 1'b1;
        next_wd = tgt;
        prev_wd = prv;
      end
      dlle_pkg::CMD_INS_LINK: begin
        prev_we = 1'b1;
        prev_wa = tgt[IW-1:0];
        prev_wd = slot;
        next_we = (prv < NIL);
        next_wa = prv[IW-1:0];
        next_wd = slot;
      end
      dlle_pkg::CMD_DEL: begin
        next_we = (prv < NIL);
        next_wa = prv[IW-1:0];
        next_wd = nxt;
        prev_we = (nxt < NIL);
        prev_wa = nxt[IW-1:0];
        prev_wd = prv;
        free_we = 1'b1;
        free_wa = tgt[IW-1:0];
        free_wd = 1'b1;
      end
      default: begin
        val_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val;
    rd_val <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    rd_next <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    rd_prev <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    rd_free <= free_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      size      <= '0;
      scan      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      size      <= size_next;
      rsp_valid <= ctl.emit;
      case (ctl.cmd)
        dlle_pkg::CMD_CLEAR:      scan <= scan + 1'b1;
        dlle_pkg::CMD_HIT,
        dlle_pkg::CMD_SCAN_START: scan <= '0;
        dlle_pkg::CMD_SCAN_STEP:  scan <= scan + 1'b1;
        dlle_pkg::CMD_APP_LINK: begin
          if (tail >= NIL) head <= slot;
          tail <= slot;
        end
        dlle_pkg::CMD_INS_LINK: begin
          if (prv >= NIL) head <= slot;
        end
        dlle_pkg::CMD_DEL: begin
          if (prv >= NIL) head <= nxt;
          if (nxt >= NIL) tail <= prv;
        end
        default: begin
          scan <= scan;
        end
      endcase
    end
  end

  // operand and walk registers
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      dlle_pkg::CMD_LOAD: begin
        op  <= req.opcode;
        val <= val_ext[VALUE_BITS-1:0];
        key <= key_ext[VALUE_BITS-1:0];
      end
      dlle_pkg::CMD_WALK_START: begin
        cur   <= head;
        steps <= '0;
      end
      dlle_pkg::CMD_WALK_STEP: begin
        cur   <= rd_next;
        steps <= steps + 1'b1;
      end
      dlle_pkg::CMD_HIT: begin
        tgt <= cur;
        prv <= rd_prev;
        nxt <= rd_next;
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp.status     <= ctl.status;
      rsp.item_value <= ctl.item ? item_ext[31:0] : 32'd0;
      rsp.last       <= ctl.last;
      rsp.node_count <= cnt_ext[6:0];
    end
  end

endmodule

// ===== hw/rtl/doubly_linked_list_engine.sv =====
// Top level of the doubly linked list engine.
// Joins dlle_ctrl and dlle_dp; uses dlle_pkg.
//
//   channel   handshake            payload
//   request   start / busy         req (dlle_pkg::req_t)
//   result    rsp_valid strobe     rsp (dlle_pkg::rsp_t)
//
// Each result word is registered in the datapath from its emit cycle.
// Append: the lowest free slot is scanned one per cycle, then written and linked.
// Delete: walks the nodes to the key; insert: walks the nodes, then scans for a free slot.
// Read out: one result per node; each step is one linked memory read.
// After reset the free map is cleared with busy high.
// Results are one-cycle strobes; the receiver cannot stall.
module doubly_linked_list_engine #(
  parameter int NODES      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dlle_pkg::req_t req,
  output dlle_pkg::rsp_t rsp,
  output logic           rsp_valid
);

  dlle_pkg::ctl_t ctl;
  dlle_pkg::sts_t sts;

  dlle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  dlle_dp #(
    .NODES      (NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

`ifndef SYNTHESIS
  a_word_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $past(busy)) else $error("result word without work in flight");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.last) |=> !rsp_valid) else $error("result word after last");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the doubly linked list engine: directed and random commands.
// Predicts each result word from its own linked list model; uses dlle_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 64;
  localparam int NIL   = NODES;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  dlle_pkg::req_t req;
  dlle_pkg::rsp_t rsp;
  logic rsp_valid;

  doubly_linked_list_engine #(.NODES(NODES), .VALUE_BITS(32)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .rsp(rsp), .rsp_valid(rsp_valid)
  );

  // list shadow
  logic signed [31:0] slot_val [NODES];
  int slot_next [NODES];
  int slot_prev [NODES];
  bit slot_used [NODES];
  int head_idx, tail_idx, list_len;

  dlle_pkg::rsp_t expected_words[$];
  int mismatches;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int find_value(logic signed [31:0] k);
    int p, steps;
    p = head_idx;
    steps = 0;
    while (p < NIL && steps < NODES) begin
      if (slot_val[p] == k) return p;
      p = slot_next[p];
      steps++;
    end
    return NIL;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < NODES; i++) if (!slot_used[i]) return i;
    return NIL;
  endfunction

  function automatic void push_word(dlle_pkg::status_t st, logic signed [31:0] v, bit lst);
    dlle_pkg::rsp_t w;
    w.status = st;
    w.item_value = v;
    w.last = lst;
    w.node_count = 7'(list_len);
    expected_words.push_back(w);
  endfunction

  function automatic void predict_list_op(dlle_pkg::req_t r);
    int s, t, p, n, k;
    case (r.opcode)
      dlle_pkg::OP_APPEND: begin
        s = lowest_free();
        if (s >= NIL) begin
          push_word(dlle_pkg::STAT_FULL, 0, 1'b1);
          return;
        end
        slot_used[s] = 1;
        slot_val[s] = r.value;
        slot_next[s] = NIL;
        slot_prev[s] = tail_idx;
        if (tail_idx < NIL) slot_next[tail_idx] = s;
        else head_idx = s;
        tail_idx = s;
        list_len++;
        push_word(dlle_pkg::STAT_OK, 0, 1'b1);
      end
      dlle_pkg::OP_INSERT, dlle_pkg::OP_DELETE: begin
        if (head_idx >= NIL) begin
          push_word(dlle_pkg::STAT_EMPTY, 0, 1'b1);
          return;
        end
        t = find_value(r.key);
        if (t >= NIL) begin
          push_word(dlle_pkg::STAT_NOT_FOUND, 0, 1'b1);
          return;
        end
        if (r.opcode == dlle_pkg::OP_INSERT) begin
          s = lowest_free();
          if (s >= NIL) begin
            push_word(dlle_pkg::STAT_FULL, 0, 1'b1);
            return;
          end
          slot_used[s] = 1;
          slot_val[s] = r.value;
          p = slot_prev[t];
          slot_next[s] = t;
          slot_prev[s] = p;
          slot_prev[t] = s;
          if (p < NIL) slot_next[p] = s;
          else head_idx = s;
          list_len++;
        end else begin
          p = slot_prev[t];
          n = slot_next[t];
          if (p < NIL) slot_next[p] = n;
          else head_idx = n;
          if (n < NIL) slot_prev[n] = p;
          else tail_idx = p;
          slot_used[t] = 0;
          if (list_len > 0) list_len--;
        end
        push_word(dlle_pkg::STAT_OK, 0, 1'b1);
      end
      default: begin
        if (head_idx >= NIL) begin
          push_word(dlle_pkg::STAT_EMPTY, 0, 1'b1);
          return;
        end
        p = head_idx;
        k = 0;
        while (p < NIL && k < NODES) begin
          n = slot_next[p];
          push_word(dlle_pkg::STAT_OK, slot_val[p], (n >= NIL || k + 1 >= NODES));
          k++;
          p = n;
        end
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", rsp);
      end else begin
        dlle_pkg::rsp_t w;
        w = expected_words.pop_front();
        if (rsp !== w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", w, rsp);
        end
      end
    end
  end

  task automatic send_cmd(dlle_pkg::op_t op, logic signed [31:0] v, logic signed [31:0] k);
    dlle_pkg::req_t r;
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    r.opcode = op;
    r.value = v;
    r.key = k;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    predict_list_op(r);
    start <= 1'b0;
    // engine is busy for this cycle anyway
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_words.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [31:0] some_stored();
    int p, k;
    if (head_idx >= NIL) return $urandom;
    k = $urandom_range(list_len - 1);
    p = head_idx;
    repeat (k) p = slot_next[p];
    return slot_val[p];
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    send_cmd(dlle_pkg::OP_READ, 0, 0);
    send_cmd(dlle_pkg::OP_INSERT, 5, 5);
    send_cmd(dlle_pkg::OP_DELETE, 0, 7);
    send_cmd(dlle_pkg::OP_APPEND, 32'sh7fffffff, 0);
    send_cmd(dlle_pkg::OP_APPEND, 32'sh80000000, 0);
    send_cmd(dlle_pkg::OP_APPEND, -1, 0);
    send_cmd(dlle_pkg::OP_APPEND, 0, 0);
    send_cmd(dlle_pkg::OP_INSERT, 11, 32'sh7fffffff);
    send_cmd(dlle_pkg::OP_INSERT, 12, 0);
    send_cmd(dlle_pkg::OP_INSERT, 13, 99);
    send_cmd(dlle_pkg::OP_APPEND, -1, 0);
    send_cmd(dlle_pkg::OP_READ, 0, 0);
    send_cmd(dlle_pkg::OP_DELETE, 0, -1);
    send_cmd(dlle_pkg::OP_DELETE, 0, 11);
    send_cmd(dlle_pkg::OP_DELETE, 0, 0);
    send_cmd(dlle_pkg::OP_DELETE, 0, 1234);
    send_cmd(dlle_pkg::OP_READ, 0, 0);
    drain();
  endtask

  // fill the pool to exercise full on append and insert, then empty it
  task automatic test_full_pool();
    idle_pct = 11;
    while (list_len < NODES) send_cmd(dlle_pkg::OP_APPEND, $urandom, 0);
    send_cmd(dlle_pkg::OP_APPEND, 1, 0);
    send_cmd(dlle_pkg::OP_INSERT, 2, some_stored());
    send_cmd(dlle_pkg::OP_INSERT, 2, 32'sh1234);
    send_cmd(dlle_pkg::OP_READ, 0, 0);
    while (list_len > 0) send_cmd(dlle_pkg::OP_DELETE, 0, some_stored());
    send_cmd(dlle_pkg::OP_DELETE, 0, 0);
    drain();
  endtask

  task automatic test_random(int count, int pct);
    int sel;
    logic signed [31:0] v;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      // small value pool so keys hit and duplicates occur
      v = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(15)) - 8;
      if (sel < 40 && list_len < 20 || sel < 15) send_cmd(dlle_pkg::OP_APPEND, v, 0);
      else if (sel < 60)
        send_cmd(dlle_pkg::OP_INSERT, v,
                 ($urandom_range(4) == 0) ? $urandom : some_stored());
      else if (sel < 88)
        send_cmd(dlle_pkg::OP_DELETE, 0,
                 ($urandom_range(4) == 0) ? $urandom : some_stored());
      else send_cmd(dlle_pkg::OP_READ, 0, 0);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    mismatches = 0;
    idle_pct = 0;
    head_idx = NIL;
    tail_idx = NIL;
    list_len = 0;
    for (int i = 0; i < NODES; i++) begin
      slot_used[i] = 0;
      slot_val[i] = 0;
      slot_next[i] = 0;
      slot_prev[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_pool();
    test_random(80, 0);
    test_random(70, 58);
    test_random(70, 11);
    test_random(50, 0);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
